// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int Depth   = 16;
  localparam int CntW    = $clog2(Depth + 1);
  localparam int TagW    = 16;
  localparam int PrioW   = 8;
  localparam int StatusW = 2;

  localparam logic CmdEnq = 1'b0;
  localparam logic CmdDeq = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic    latch;
    op_e     op;
    logic    rsp_load;
    status_e rsp_status;
  } spq_ctrl_t;

  typedef struct packed {
    logic cmd_deq;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// File: src/spq_datapath.sv
// Datapath of the sorted priority queue: entry cells, command latch and result register.
module spq_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spq_pkg::spq_ctrl_t          ctrl_i,
  output spq_pkg::spq_stat_t          stat_o,
  input  logic                        cmd_i,
  input  logic [spq_pkg::TagW-1:0]    tag_i,
  input  logic [spq_pkg::PrioW-1:0]   priority_req_i,
  output logic [spq_pkg::StatusW-1:0] status_o,
  output logic [spq_pkg::TagW-1:0]    out_tag_o,
  output logic [spq_pkg::PrioW-1:0]   out_priority_o,
  output logic [spq_pkg::CntW-1:0]    occupancy_o
);

  logic                       cmd_q;
  logic [spq_pkg::TagW-1:0]   tag_in_q;
  logic [spq_pkg::PrioW-1:0]  prio_in_q;
  logic [spq_pkg::CntW-1:0]   count_q;
  logic [spq_pkg::CntW-1:0]   count_d;
  logic [spq_pkg::TagW-1:0]   tag_q [spq_pkg::Depth];
  logic [spq_pkg::PrioW-1:0]  prio_q [spq_pkg::Depth];
  logic [spq_pkg::Depth-1:0]  lt;
  logic [spq_pkg::Depth-1:0]  move;
  logic [spq_pkg::Depth-1:0]  ins;
  logic [spq_pkg::StatusW-1:0] status_q;
  logic [spq_pkg::TagW-1:0]   out_tag_q;
  logic [spq_pkg::PrioW-1:0]  out_prio_q;
  logic [spq_pkg::CntW-1:0]   occ_q;

  // Each cell compares its own priority with the new one; held entries form a thermometer.
  always_comb begin
    for (int k = 0; k < spq_pkg::Depth; k++) begin
      lt[k] = (spq_pkg::CntW'(k) < count_q) && (prio_q[k] < prio_in_q);
    end
    move[0] = 1'b0;
    for (int k = 1; k < spq_pkg::Depth; k++) begin
      move[k] = lt[k-1];
    end
    for (int k = 0; k < spq_pkg::Depth; k++) begin
      ins[k] = (spq_pkg::CntW'(k) <= count_q) && !move[k] &&
               ((spq_pkg::CntW'(k) == count_q) || lt[k]);
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      spq_pkg::OP_INSERT: count_d = count_q + spq_pkg::CntW'(1);
      spq_pkg::OP_REMOVE: count_d = count_q - spq_pkg::CntW'(1);
      default:            count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q     <= cmd_i;
      tag_in_q  <= tag_i;
      prio_in_q <= priority_req_i;
    end
    if (ctrl_i.op == spq_pkg::OP_INSERT) begin
      if (ins[0]) begin
        tag_q[0]  <= tag_in_q;
        prio_q[0] <= prio_in_q;
      end
      for (int k = 1; k < spq_pkg::Depth; k++) begin
        if (move[k]) begin
          tag_q[k]  <= tag_q[k-1];
          prio_q[k] <= prio_q[k-1];
        end else if (ins[k]) begin
          tag_q[k]  <= tag_in_q;
          prio_q[k] <= prio_in_q;
        end
      end
    end else if (ctrl_i.op == spq_pkg::OP_REMOVE) begin
      for (int k = 0; k < spq_pkg::Depth - 1; k++) begin
        tag_q[k]  <= tag_q[k+1];
        prio_q[k] <= prio_q[k+1];
      end
    end
    if (ctrl_i.rsp_load) begin
      status_q <= ctrl_i.rsp_status;
      occ_q    <= count_d;
      if (ctrl_i.op == spq_pkg::OP_REMOVE) begin
        out_tag_q  <= tag_q[0];
        out_prio_q <= prio_q[0];
      end else begin
        out_tag_q  <= '0;
        out_prio_q <= '0;
      end
    end
  end

  assign stat_o.cmd_deq = (cmd_q == spq_pkg::CmdDeq);
  assign stat_o.full    = (count_q == spq_pkg::CntW'(spq_pkg::Depth));
  assign stat_o.empty   = (count_q == '0);

  assign status_o       = status_q;
  assign out_tag_o      = out_tag_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = occ_q;

endmodule

// File: src/spq_ctrl.sv
// Controller of the sorted priority queue: handshakes and operation sequencing.
module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_ctrl_t ctrl_o
);

  spq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    out_valid_d       = out_valid_q && out_stall_i;
    in_stall_o        = 1'b1;
    ctrl_o.latch      = 1'b0;
    ctrl_o.op         = spq_pkg::OP_NONE;
    ctrl_o.rsp_load   = 1'b0;
    ctrl_o.rsp_status = spq_pkg::ST_OK;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i;
        if (in_valid_i && !in_stall_o) begin
          ctrl_o.latch = 1'b1;
          state_d      = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        ctrl_o.rsp_load = 1'b1;
        out_valid_d     = 1'b1;
        state_d         = spq_pkg::S_IDLE;
        if (stat_i.cmd_deq) begin
          if (stat_i.empty) begin
            ctrl_o.rsp_status = spq_pkg::ST_EMPTY;
          end else begin
            ctrl_o.op = spq_pkg::OP_REMOVE;
          end
        end else begin
          if (stat_i.full) begin
            ctrl_o.rsp_status = spq_pkg::ST_FULL;
          end else begin
            ctrl_o.op = spq_pkg::OP_INSERT;
          end
        end
      end
      default: state_d = spq_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/sorted_priority_queue.sv
// Top level of the sorted priority queue.
//
//   Channel | Direction | Handshake               | Fields
//   input   | in        | in_valid_i, in_stall_o  | cmd_i, tag_i, priority_req_i
//   output  | out       | out_valid_o, out_stall_i| status_o, out_tag_o, out_priority_o,
//           |           |                         | occupancy_o
//
// Each word is latched in S_IDLE; in S_EXEC every entry cell compares against the new
// priority and shifts or loads in parallel, or, on a dequeue, all entries shift to the head.
// One result word is produced per input word and held in an output register.
// A new word is accepted while the previous result is still waiting, unless it stays stalled.
// Reset empties the queue; the entry cells themselves are not cleared.
module sorted_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [spq_pkg::TagW-1:0]    tag_i,
  input  logic [spq_pkg::PrioW-1:0]   priority_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spq_pkg::StatusW-1:0] status_o,
  output logic [spq_pkg::TagW-1:0]    out_tag_o,
  output logic [spq_pkg::PrioW-1:0]   out_priority_o,
  output logic [spq_pkg::CntW-1:0]    occupancy_o
);

  spq_pkg::spq_ctrl_t ctrl;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .tag_i          (tag_i),
    .priority_req_i (priority_req_i),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an operation is in flight");

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o)
    else $error("no result after accepted word");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue with a mirror queue as predictor.
module tb;

  typedef struct {
    spq_pkg::status_e          status;
    logic [spq_pkg::TagW-1:0]  tag;
    logic [spq_pkg::PrioW-1:0] prio;
    logic [spq_pkg::CntW-1:0]  count;
  } queue_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        cmd_i;
  logic [spq_pkg::TagW-1:0]    tag_i;
  logic [spq_pkg::PrioW-1:0]   priority_req_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [spq_pkg::StatusW-1:0] status_o;
  logic [spq_pkg::TagW-1:0]    out_tag_o;
  logic [spq_pkg::PrioW-1:0]   out_priority_o;
  logic [spq_pkg::CntW-1:0]    occupancy_o;

  logic [spq_pkg::TagW-1:0]  held_tag [spq_pkg::Depth];
  logic [spq_pkg::PrioW-1:0] held_prio [spq_pkg::Depth];
  int                        held_count = 0;
  queue_result_t             awaited_results [$];
  int                        mismatch_count = 0;
  bit                        sender_calm = 1'b0;
  bit                        receiver_calm = 1'b0;
  int                        hold_request = 0;
  int                        hold_left = 0;

  sorted_priority_queue dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  // The mirror applies one queue operation and returns the result word it must cause.
  function automatic queue_result_t predict_queue_op(logic cmd,
                                                     logic [spq_pkg::TagW-1:0] t,
                                                     logic [spq_pkg::PrioW-1:0] p);
    queue_result_t r;
    int slot;
    r.status = spq_pkg::ST_OK;
    r.tag    = '0;
    r.prio   = '0;
    if (cmd == spq_pkg::CmdEnq) begin
      if (held_count >= spq_pkg::Depth) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        slot = held_count;
        while (slot > 0 && held_prio[slot-1] < p) begin
          held_tag[slot]  = held_tag[slot-1];
          held_prio[slot] = held_prio[slot-1];
          slot--;
        end
        held_tag[slot]  = t;
        held_prio[slot] = p;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.tag  = held_tag[0];
      r.prio = held_prio[0];
      for (int k = 1; k < held_count; k++) begin
        held_tag[k-1]  = held_tag[k];
        held_prio[k-1] = held_prio[k];
      end
      held_count--;
    end
    r.count = held_count[spq_pkg::CntW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    queue_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: status %0d tag %h prio %0d occ %0d",
                     status_o, out_tag_o, out_priority_o, occupancy_o);
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status || out_tag_o !== want.tag ||
              out_priority_o !== want.prio || occupancy_o !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: expected status %0d tag %h prio %0d occ %0d, ",
                        "got %0d %h %0d %0d"},
                       want.status, want.tag, want.prio, want.count,
                       status_o, out_tag_o, out_priority_o, occupancy_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        awaited_results.push_back(predict_queue_op(cmd_i, tag_i, priority_req_i));
    end
  end

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !receiver_calm && ($urandom_range(99) < 20);
    end
  end

  task automatic send_word(logic cmd, logic [spq_pkg::TagW-1:0] t,
                           logic [spq_pkg::PrioW-1:0] p);
    int gap;
    @(negedge clk_i);
    if (!sender_calm && $urandom_range(99) < 20) begin
      gap = $urandom_range(3, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    tag_i          <= t;
    priority_req_i <= p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic pause_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  function automatic logic [spq_pkg::PrioW-1:0] pick_prio(bit narrow);
    if (narrow)
      return ($urandom_range(1) ? 8'hFC : 8'h00) | 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_words(int n, int enq_pct, bit narrow);
    repeat (n)
      send_word(($urandom_range(99) < enq_pct) ? spq_pkg::CmdEnq : spq_pkg::CmdDeq,
                16'($urandom()), pick_prio(narrow));
  endtask

  task automatic test_directed();
    send_word(spq_pkg::CmdDeq, 16'hFFFF, 8'hFF);
    send_word(spq_pkg::CmdEnq, 16'h0000, 8'h00);
    send_word(spq_pkg::CmdEnq, 16'hFFFF, 8'hFF);
    send_word(spq_pkg::CmdEnq, 16'h1111, 8'h80);
    send_word(spq_pkg::CmdEnq, 16'h2222, 8'h80);
    send_word(spq_pkg::CmdEnq, 16'h3333, 8'h80);
    send_word(spq_pkg::CmdEnq, 16'h0005, 8'hFF);
    send_word(spq_pkg::CmdEnq, 16'h8000, 8'h00);
    send_word(spq_pkg::CmdEnq, 16'h4444, 8'h7F);
    repeat (8) send_word(spq_pkg::CmdDeq, 16'($urandom()), 8'($urandom()));
    send_word(spq_pkg::CmdDeq, 16'h0000, 8'h00);
    pause_sender();
  endtask

  task automatic test_full_and_empty(bit narrow);
    repeat (spq_pkg::Depth + 2)
      send_word(spq_pkg::CmdEnq, 16'($urandom()), pick_prio(narrow));
    repeat (spq_pkg::Depth + 2)
      send_word(spq_pkg::CmdDeq, 16'($urandom()), 8'($urandom()));
    pause_sender();
  endtask

  task automatic test_random_mix();
    int enq_rates [8] = '{50, 85, 20, 60, 95, 5, 55, 45};
    for (int blk = 0; blk < 13; blk++)
      random_words(100, enq_rates[blk % 8], blk[0]);
  endtask

  task automatic test_no_idle();
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    random_words(150, 55, 1'b0);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    sender_calm  = 1'b1;
    hold_request = 80;
    random_words(30, 70, 1'b1);
    sender_calm  = 1'b0;
    pause_sender();
  endtask

  task automatic test_sender_pause();
    random_words(20, 70, 1'b0);
    pause_sender();
    random_words(20, 40, 1'b0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = spq_pkg::CmdEnq;
    tag_i          = '0;
    priority_req_i = '0;
    out_stall_i    = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_and_empty(1'b0);
    test_full_and_empty(1'b1);
    test_random_mix();
    test_no_idle();
    test_backpressure();
    test_sender_pause();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
